FILE: hdl/pwtok_pkg.sv
// Shared types and constants for the pipe and whitespace tokenizer.
// Used by the front, back and top-level modules; depends on nothing else.

package pwtok_pkg;

    // Fixed widths of the result fields.
    localparam int unsigned CMD_OUT_W   = 4;
    localparam int unsigned ARG_OUT_W   = 6;
    localparam int unsigned START_OUT_W = 12;
    localparam int unsigned LEN_OUT_W   = 13;
    localparam int unsigned TOTAL_OUT_W = 5;

    // Character codes that steer the split.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    // Record kind codes.
    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One queue entry: the records that one input item causes.
    typedef struct packed {
        logic                   tok_valid;
        logic [CMD_OUT_W-1:0]   cmd;
        logic [ARG_OUT_W-1:0]   arg;
        logic [START_OUT_W-1:0] start;
        logic [LEN_OUT_W-1:0]   len;
        logic                   sum_valid;
        logic [TOTAL_OUT_W-1:0] total;
    } t_rec;

endpackage

FILE: hdl/pipe_and_whitespace_tokenizer_core.sv
// Top level of the pipe and whitespace tokenizer.
// Depends on pwtok_pkg, pwtok_front, pwtok_fifo and pwtok_back.

// The block takes a command line one byte per cycle and reports one token record for
// each kept token (command index, argument index, start offset, length) and a summary
// record with the command count after the byte marked as the line end. A byte is
// classified and the line state updated in the cycle it is accepted, so bytes stream
// in at one per cycle; the records of a byte enter a four-entry queue and leave
// through a registered output, one record per cycle while the receiver is ready.
// A line-end byte that also closes a token sends its token record, then its summary.
// The input stalls only while the queue is full. No clearing pass follows reset.

module pipe_and_whitespace_tokenizer_core
    import pwtok_pkg::*;
#(
    parameter int unsigned ARG_SLOTS     = 64,
    parameter int unsigned COMMAND_SLOTS = 16,
    parameter int unsigned LINE_BYTES    = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_line_byte,
    input  logic                   i_line_end,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_record_kind,
    output logic [CMD_OUT_W-1:0]   o_command_index,
    output logic [ARG_OUT_W-1:0]   o_argument_index,
    output logic [START_OUT_W-1:0] o_token_start,
    output logic [LEN_OUT_W-1:0]   o_token_length,
    output logic [TOTAL_OUT_W-1:0] o_command_total,
    output logic                   o_final_record
);

    localparam int unsigned QUEUE_DEPTH = 4;

    logic accept;
    logic push;
    logic full;
    logic empty;
    logic pop;
    t_rec front_rec;
    t_rec head_rec;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    // Byte classification and line state.
    pwtok_front #(
        .ARG_SLOTS     (ARG_SLOTS),
        .COMMAND_SLOTS (COMMAND_SLOTS),
        .LINE_BYTES    (LINE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_line_byte (i_line_byte),
        .i_line_end  (i_line_end),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    // Queue between the two parts.
    pwtok_fifo #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_rec),
        .o_empty (empty)
    );

    // Record output.
    pwtok_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_rec),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_record_kind    (o_record_kind),
        .o_command_index  (o_command_index),
        .o_argument_index (o_argument_index),
        .o_token_start    (o_token_start),
        .o_token_length   (o_token_length),
        .o_command_total  (o_command_total),
        .o_final_record   (o_final_record)
    );

endmodule

FILE: hdl/pwtok_fifo.sv
// Small first-in first-out queue of flip-flops between the front and back parts.
// Generic in width and depth; depends on no package.

module pwtok_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage is written only, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap at the depth; the count tells full from empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/pwtok_front.sv
// Front part: classifies each byte, keeps the line state and builds queue entries.
// Depends on pwtok_pkg for the character codes and the entry type.

module pwtok_front
    import pwtok_pkg::*;
#(
    parameter int unsigned ARG_SLOTS     = 64,
    parameter int unsigned COMMAND_SLOTS = 16,
    parameter int unsigned LINE_BYTES    = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_line_byte,
    input  logic       i_line_end,
    output logic       o_push,
    output t_rec       o_rec
);

    localparam int unsigned POS_W = $clog2(LINE_BYTES + 1);
    localparam int unsigned OFF_W = $clog2(LINE_BYTES);
    localparam int unsigned ARG_W = $clog2(ARG_SLOTS);
    localparam int unsigned CMD_W = $clog2(COMMAND_SLOTS + 1);

    logic [POS_W-1:0] r_pos,    n_pos;
    logic             r_inside, n_inside;
    logic [OFF_W-1:0] r_cts,    n_cts;
    logic [ARG_W-1:0] r_seg,    n_seg;
    logic [CMD_W-1:0] r_cf,     n_cf;
    logic             r_skip,   n_skip;
    logic             r_stop,   n_stop;

    logic             brk_line;
    logic             is_pipe;
    logic             is_ws;
    logic [POS_W-1:0] tok_len;

    // Byte classes; a byte past the line size acts as a zero byte.
    always_comb begin
        brk_line = (i_line_byte == CH_NUL) || (r_pos >= POS_W'(LINE_BYTES));
        is_pipe  = (i_line_byte == CH_PIPE);
        is_ws    = (i_line_byte == CH_SPACE) || (i_line_byte == CH_TAB) ||
                   (i_line_byte == CH_CR) || (i_line_byte == CH_LF);
    end

    // Next line state and the records this byte causes.
    always_comb begin
        n_pos    = r_pos;
        n_inside = r_inside;
        n_cts    = r_cts;
        n_seg    = r_seg;
        n_cf     = r_cf;
        n_skip   = r_skip;
        n_stop   = r_stop;
        tok_len  = '0;
        o_rec    = '0;

        if (!r_stop) begin
            if (brk_line || is_pipe || is_ws) begin
                // A separator closes the open token.
                if (n_inside) begin
                    tok_len         = r_pos - POS_W'(n_cts);
                    o_rec.tok_valid = 1'b1;
                    o_rec.cmd       = CMD_OUT_W'(n_cf);
                    o_rec.arg       = ARG_OUT_W'(n_seg);
                    o_rec.start     = START_OUT_W'(n_cts);
                    o_rec.len       = LEN_OUT_W'(tok_len);
                    n_seg           = n_seg + 1'b1;
                    n_inside        = 1'b0;
                    if (n_seg >= ARG_W'(ARG_SLOTS - 1)) begin
                        n_skip = 1'b1;
                    end
                end
                // A pipe or a line break also closes the segment.
                if (brk_line || is_pipe) begin
                    if (n_seg != '0) begin
                        n_cf = n_cf + 1'b1;
                    end
                    n_seg    = '0;
                    n_skip   = 1'b0;
                    n_inside = 1'b0;
                    if (brk_line || (n_cf >= CMD_W'(COMMAND_SLOTS))) begin
                        n_stop = 1'b1;
                    end
                end
            end else if (!n_inside && !n_skip) begin
                n_inside = 1'b1;
                n_cts    = r_pos[OFF_W-1:0];
            end
            if (r_pos < POS_W'(LINE_BYTES)) begin
                n_pos = r_pos + 1'b1;
            end
        end

        // The last byte closes what is still open and adds the summary.
        if (i_line_end) begin
            if (!n_stop) begin
                if (n_inside) begin
                    tok_len         = n_pos - POS_W'(n_cts);
                    o_rec.tok_valid = 1'b1;
                    o_rec.cmd       = CMD_OUT_W'(n_cf);
                    o_rec.arg       = ARG_OUT_W'(n_seg);
                    o_rec.start     = START_OUT_W'(n_cts);
                    o_rec.len       = LEN_OUT_W'(tok_len);
                    n_seg           = n_seg + 1'b1;
                end
                if (n_seg != '0) begin
                    n_cf = n_cf + 1'b1;
                end
            end
            o_rec.sum_valid = 1'b1;
            o_rec.total     = TOTAL_OUT_W'(n_cf);
            n_pos    = '0;
            n_inside = 1'b0;
            n_cts    = '0;
            n_seg    = '0;
            n_cf     = '0;
            n_skip   = 1'b0;
            n_stop   = 1'b0;
        end
    end

    assign o_push = i_accept && (o_rec.tok_valid || o_rec.sum_valid);

    // Line state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_inside <= 1'b0;
            r_cts    <= '0;
            r_seg    <= '0;
            r_cf     <= '0;
            r_skip   <= 1'b0;
            r_stop   <= 1'b0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_inside <= n_inside;
            r_cts    <= n_cts;
            r_seg    <= n_seg;
            r_cf     <= n_cf;
            r_skip   <= n_skip;
            r_stop   <= n_stop;
        end
    end

endmodule

FILE: hdl/pwtok_back.sv
// Back part: takes queue entries and sends their records one at a time.
// Depends on pwtok_pkg for the entry type and the record kind codes.

module pwtok_back
    import pwtok_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_rec                   i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_record_kind,
    output logic [CMD_OUT_W-1:0]   o_command_index,
    output logic [ARG_OUT_W-1:0]   o_argument_index,
    output logic [START_OUT_W-1:0] o_token_start,
    output logic [LEN_OUT_W-1:0]   o_token_length,
    output logic [TOTAL_OUT_W-1:0] o_command_total,
    output logic                   o_final_record
);

    logic r_valid;
    logic r_half;
    logic load;
    logic emit_tok;

    // The output register loads when it is empty or being drained.
    assign load     = !i_empty && (!r_valid || i_ready);
    assign emit_tok = i_head.tok_valid && !r_half;
    assign o_pop    = load && (!emit_tok || !i_head.sum_valid);
    assign o_valid  = r_valid;

    // Handshake state; the half flag marks a token already sent ahead of its summary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= emit_tok && i_head.sum_valid;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Record payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_tok) begin
                o_record_kind    <= KIND_TOKEN;
                o_command_index  <= i_head.cmd;
                o_argument_index <= i_head.arg;
                o_token_start    <= i_head.start;
                o_token_length   <= i_head.len;
                o_command_total  <= '0;
                o_final_record   <= 1'b0;
            end else begin
                o_record_kind    <= KIND_SUMMARY;
                o_command_index  <= '0;
                o_argument_index <= '0;
                o_token_start    <= '0;
                o_token_length   <= '0;
                o_command_total  <= i_head.total;
                o_final_record   <= 1'b1;
            end
        end
    end

endmodule
